// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the chain block allocator.
// No dependencies; files that check their own logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising edge, skipped while reset is asserted.
`define ASSERT_ON_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define ASSERT_ON_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS_CLK(lbl, clk, prop)

`endif

`endif

// ----- rtl/fcba_pkg.sv -----
// Package of the chain block allocator: entry encoding, codes and types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fcba_pkg;

    localparam int DEF_NUM_BLOCKS = 64;

    localparam int ENTRY_W  = 8;
    localparam int OP_W     = 2;
    localparam int BLK_W    = 6;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    localparam logic [ENTRY_W-1:0] ENTRY_END  = 8'd254;
    localparam logic [ENTRY_W-1:0] ENTRY_FREE = 8'd255;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_EXTEND = 2'd1,
        OP_FREE   = 2'd2,
        OP_COUNT  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_START_FREE = 2'd2,
        ST_BROKEN     = 2'd3
    } status_t;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_TAIL = 7'b0000010,
        S_SCAN = 7'b0000100,
        S_MARK = 7'b0001000,
        S_LINK = 7'b0010000,
        S_WALK = 7'b0100000,
        S_RESP = 7'b1000000
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/fcba_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fcba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/fat_chain_block_allocator.sv -----
// Top level of the chain block allocator: link table in RAM and its sequencer.
// Depends on fcba_pkg, fcba_ram and assert_macros.svh.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_ready, operation, block     | request
//  out     | out_valid, out_ready, result_block,      | response
//          | chain_count, status                      |
//
// Allocate and extend run a free search that reads one table entry per cycle
// from the single RAM read port. Free and count walk the chain one block after another.
// Reset marks every entry free at once through per-entry valid bits.
// One request at a time; a finished response waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fat_chain_block_allocator
    import fcba_pkg::*;
#(
    parameter int NUM_BLOCKS = DEF_NUM_BLOCKS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [OP_W-1:0]     operation,
    input  wire logic [BLK_W-1:0]    block,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic      [BLK_W-1:0]    result_block,
    output logic      [COUNT_W-1:0]  chain_count,
    output logic      [STATUS_W-1:0] status
);

    localparam int IW = $clog2(NUM_BLOCKS);
    localparam int CW = $clog2(NUM_BLOCKS + 1);
    localparam logic [IW-1:0]      LAST_IDX = IW'(NUM_BLOCKS - 1);
    localparam logic [ENTRY_W-1:0] N_ENTRY  = ENTRY_W'(NUM_BLOCKS);
    localparam logic [CW-1:0]      N_COUNT  = CW'(NUM_BLOCKS);
    localparam logic [8:0]         N_BLK    = 9'(NUM_BLOCKS);

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [IW-1:0]       blk_reg, blk_next;
    logic [IW-1:0]       cur_reg, cur_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                first_reg, first_next;
    logic [IW-1:0]       scan_reg, scan_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [IW-1:0]       chk_idx_reg, chk_idx_next;
    logic [IW-1:0]       found_reg, found_next;
    logic [BLK_W-1:0]    res_blk_reg, res_blk_next;
    status_t             res_st_reg, res_st_next;
    logic                out_valid_reg, out_valid_next;
    logic [BLK_W-1:0]    out_blk_reg, out_blk_next;
    logic [COUNT_W-1:0]  out_cnt_reg, out_cnt_next;
    status_t             out_st_reg, out_st_next;
    logic                valid_reg [NUM_BLOCKS];
    logic                vq_reg;
    logic                fwd_hit_reg;
    logic [ENTRY_W-1:0]  fwd_data_reg;

    logic                ram_wr_en;
    logic [IW-1:0]       ram_wr_addr;
    logic [ENTRY_W-1:0]  ram_wr_data;
    logic                ram_rd_en;
    logic [IW-1:0]       ram_rd_addr;
    logic [ENTRY_W-1:0]  ram_rd_data;

    logic [ENTRY_W-1:0]  ent;
    logic                ent_free;
    logic                in_fire;
    logic                blk_in_range;
    logic                out_free;

    fcba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_BLOCKS)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign ent          = fwd_hit_reg ? fwd_data_reg : (vq_reg ? ram_rd_data : ENTRY_FREE);
    assign ent_free     = (ent == ENTRY_FREE);
    assign in_ready     = (state_reg == S_IDLE);
    assign in_fire      = in_valid && in_ready;
    assign blk_in_range = ({3'b000, block} < N_BLK);
    assign out_free     = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign result_block = out_blk_reg;
    assign chain_count  = out_cnt_reg;
    assign status       = out_st_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        blk_next       = blk_reg;
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        first_next     = first_reg;
        scan_next      = scan_reg;
        chk_vld_next   = 1'b0;
        chk_idx_next   = chk_idx_reg;
        found_next     = found_reg;
        res_blk_next   = res_blk_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_blk_next   = out_blk_reg;
        out_cnt_next   = out_cnt_reg;
        out_st_next    = out_st_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = cur_reg;
        ram_wr_data    = ENTRY_FREE;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = scan_reg;

        case (state_reg)
            S_IDLE:
            begin
                ram_rd_en   = in_valid;
                ram_rd_addr = IW'(block);
                if (in_fire)
                begin
                    op_next      = op_t'(operation);
                    blk_next     = IW'(block);
                    cur_next     = IW'(block);
                    cnt_next     = '0;
                    first_next   = 1'b1;
                    scan_next    = '0;
                    res_blk_next = '0;
                    res_st_next  = ST_OK;
                    case (op_t'(operation))
                        OP_ALLOC:
                        begin
                            state_next = S_SCAN;
                        end
                        OP_EXTEND:
                        begin
                            if (blk_in_range)
                            begin
                                state_next = S_TAIL;
                            end
                            else
                            begin
                                res_st_next = ST_START_FREE;
                                state_next  = S_RESP;
                            end
                        end
                        default:
                        begin
                            if (blk_in_range)
                            begin
                                state_next = S_WALK;
                            end
                            else
                            begin
                                res_st_next = ST_START_FREE;
                                state_next  = S_RESP;
                            end
                        end
                    endcase
                end
            end

            S_TAIL:
            begin
                if (ent_free)
                begin
                    res_st_next = ST_START_FREE;
                    state_next  = S_RESP;
                end
                else if (ent != ENTRY_END)
                begin
                    res_st_next = ST_BROKEN;
                    state_next  = S_RESP;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                ram_rd_en    = 1'b1;
                ram_rd_addr  = scan_reg;
                scan_next    = (scan_reg == LAST_IDX) ? scan_reg : scan_reg + 1'b1;
                chk_vld_next = 1'b1;
                chk_idx_next = scan_reg;
                if (chk_vld_reg)
                begin
                    if (ent_free)
                    begin
                        found_next = chk_idx_reg;
                        state_next = S_MARK;
                    end
                    else if (chk_idx_reg == LAST_IDX)
                    begin
                        res_st_next = ST_FULL;
                        state_next  = S_RESP;
                    end
                end
            end

            S_MARK:
            begin
                ram_wr_en    = 1'b1;
                ram_wr_addr  = found_reg;
                ram_wr_data  = ENTRY_END;
                res_blk_next = BLK_W'(found_reg);
                state_next   = (op_reg == OP_EXTEND) ? S_LINK : S_RESP;
            end

            S_LINK:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = blk_reg;
                ram_wr_data = ENTRY_W'(found_reg);
                state_next  = S_RESP;
            end

            S_WALK:
            begin
                if (first_reg && ent_free)
                begin
                    res_st_next = ST_START_FREE;
                    state_next  = S_RESP;
                end
                else if (!first_reg && (ent_free || cnt_reg >= N_COUNT))
                begin
                    res_st_next = ST_BROKEN;
                    state_next  = S_RESP;
                end
                else
                begin
                    ram_wr_en   = (op_reg == OP_FREE);
                    ram_wr_addr = cur_reg;
                    ram_wr_data = ENTRY_FREE;
                    cnt_next    = cnt_reg + 1'b1;
                    if (ent == ENTRY_END)
                    begin
                        res_blk_next = (op_reg == OP_FREE) ? BLK_W'(cur_reg) : '0;
                        state_next   = S_RESP;
                    end
                    else if (ent >= N_ENTRY)
                    begin
                        res_st_next = ST_BROKEN;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = IW'(ent);
                        cur_next    = IW'(ent);
                        first_next  = 1'b0;
                    end
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_blk_next   = res_st_reg == ST_OK ? res_blk_reg : '0;
                    out_cnt_next   = COUNT_W'(cnt_reg);
                    out_st_next    = res_st_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            chk_vld_reg   <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            for (int i = 0; i < NUM_BLOCKS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            chk_vld_reg   <= chk_vld_next;
            fwd_hit_reg   <= ram_wr_en && ram_rd_en && (ram_wr_addr == ram_rd_addr);
            if (ram_wr_en)
            begin
                valid_reg[ram_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        blk_reg      <= blk_next;
        cur_reg      <= cur_next;
        cnt_reg      <= cnt_next;
        first_reg    <= first_next;
        scan_reg     <= scan_next;
        chk_idx_reg  <= chk_idx_next;
        found_reg    <= found_next;
        res_blk_reg  <= res_blk_next;
        res_st_reg   <= res_st_next;
        out_blk_reg  <= out_blk_next;
        out_cnt_reg  <= out_cnt_next;
        out_st_reg   <= out_st_next;
        vq_reg       <= valid_reg[ram_rd_addr];
        fwd_data_reg <= ram_wr_data;
    end

    `ASSERT_ON_CLK(a_count_walk_no_write, clk, rst_n, (state_reg == S_WALK && op_reg == OP_COUNT) |-> !ram_wr_en)
    `ASSERT_ON_CLK(a_count_bounded, clk, rst_n, (state_reg == S_WALK) |-> (cnt_reg <= N_COUNT))
    `ASSERT_ON_CLK(a_accept_leaves_idle, clk, rst_n, in_fire |=> (state_reg != S_IDLE))
    `ASSERT_ON_CLK(a_full_zero_block, clk, rst_n, (out_valid && status == ST_FULL) |-> (result_block == '0))

endmodule

`default_nettype wire

// ----- tb/chain_table_checker.sv -----
// Checker for the chain block allocator: watches both channels, keeps its own link table,
// predicts every response and compares it field by field with what the block returns.
// Depends on fcba_pkg.
`timescale 1ns / 1ps

module chain_table_checker
    import fcba_pkg::*;
#(
    parameter int NUM_BLOCKS = DEF_NUM_BLOCKS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [OP_W-1:0]     operation,
    input  logic [BLK_W-1:0]    block,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [BLK_W-1:0]    result_block,
    input  logic [COUNT_W-1:0]  chain_count,
    input  logic [STATUS_W-1:0] status,
    output int                  mismatches,
    output int                  in_flight
);

    typedef struct packed {
        logic [BLK_W-1:0]   res_blk;
        logic [COUNT_W-1:0] walked;
        status_t            code;
    } outcome_t;

    logic [ENTRY_W-1:0] links [NUM_BLOCKS];
    outcome_t           expected_results [$];
    int                 fail_total = 0;
    int                 response_index = 0;

    function automatic int lowest_free();
        for (int i = 0; i < NUM_BLOCKS; i++)
        begin
            if (links[i] == ENTRY_FREE)
                return i;
        end
        return -1;
    endfunction

    function automatic bit block_in_use(input logic [BLK_W-1:0] blk);
        return int'(blk) < NUM_BLOCKS && links[blk] != ENTRY_FREE;
    endfunction

    task automatic predict_request(input op_t op, input logic [BLK_W-1:0] blk,
                                   output outcome_t res);
        int cur;
        int nxt;
        int spare;
        int walked;
        bit done;
        res = '{res_blk: '0, walked: '0, code: ST_OK};
        walked = 0;
        if (op == OP_ALLOC)
        begin
            spare = lowest_free();
            if (spare < 0)
                res.code = ST_FULL;
            else
            begin
                links[spare] = ENTRY_END;
                res.res_blk = spare[BLK_W-1:0];
            end
        end
        else if (op == OP_EXTEND)
        begin
            if (!block_in_use(blk))
                res.code = ST_START_FREE;
            else if (links[blk] != ENTRY_END)
                res.code = ST_BROKEN;
            else
            begin
                spare = lowest_free();
                if (spare < 0)
                    res.code = ST_FULL;
                else
                begin
                    links[spare] = ENTRY_END;
                    links[blk] = spare[ENTRY_W-1:0];
                    res.res_blk = spare[BLK_W-1:0];
                end
            end
        end
        else if (!block_in_use(blk))
            res.code = ST_START_FREE;
        else
        begin
            // walk the chain; freeing clears each entry as it is visited
            cur = int'(blk);
            done = 1'b0;
            while (!done)
            begin
                nxt = int'(links[cur]);
                if (op == OP_FREE)
                    links[cur] = ENTRY_FREE;
                walked++;
                if (nxt == int'(ENTRY_END))
                begin
                    if (op == OP_FREE)
                        res.res_blk = cur[BLK_W-1:0];
                    done = 1'b1;
                end
                else if (nxt >= NUM_BLOCKS || links[nxt] == ENTRY_FREE)
                begin
                    res.code = ST_BROKEN;
                    done = 1'b1;
                end
                else if (walked >= NUM_BLOCKS)
                begin
                    res.code = ST_BROKEN;
                    done = 1'b1;
                end
                else
                    cur = nxt;
            end
            res.walked = walked[COUNT_W-1:0];
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        outcome_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BLOCKS; i++)
                links[i] = ENTRY_FREE;
            expected_results.delete();
            in_flight <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_request(op_t'(operation), block, want);
                expected_results.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                response_index++;
                if (expected_results.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= 10)
                    begin
                        $write("response %0d: unexpected transaction, ", response_index);
                        $display("block %0d count %0d status %0d",
                                 result_block, chain_count, status);
                    end
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_block !== want.res_blk || chain_count !== want.walked
                        || status !== want.code)
                    begin
                        fail_total++;
                        if (fail_total <= 10)
                        begin
                            $write("response %0d: block exp %0d got %0d, ", response_index,
                                   want.res_blk, result_block);
                            $write("count exp %0d got %0d, ", want.walked, chain_count);
                            $display("status exp %0d got %0d", want.code, status);
                        end
                    end
                end
            end
            in_flight <= expected_results.size();
            mismatches <= fail_total;
        end
    end

endmodule

// ----- tb/testbench.sv -----
// Top of the chain block allocator testbench: clock, reset, request stimulus, response
// back-pressure and the verdict. Depends on fcba_pkg, chain_table_checker and the block.
`timescale 1ns / 1ps

module testbench;
    import fcba_pkg::*;

    localparam int NUM_BLOCKS      = DEF_NUM_BLOCKS;
    localparam int RANDOM_ITEMS    = 700;
    localparam int SEGMENT_ITEMS   = 140;
    localparam int GROW_ITEMS      = 90;
    localparam int HOLD_OFF_AT     = 120;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = NUM_BLOCKS + 8;
    localparam int CYCLE_LIMIT     = 400000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [OP_W-1:0]     operation = OP_ALLOC;
    logic [BLK_W-1:0]    block = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [BLK_W-1:0]    result_block;
    logic [COUNT_W-1:0]  chain_count;
    logic [STATUS_W-1:0] status;
    int                  mismatches;
    int                  in_flight;

    int                  send_idle_pct = 19;
    int                  recv_idle_pct = 47;
    int                  hold_off_asked = 0;
    int                  hold_off_taken = 0;
    int                  cycle_count = 0;

    bit [BLK_W-1:0]      last_block;
    bit [BLK_W-1:0]      recent_blocks [8];
    bit [2:0]            recent_slot;

    always #5 clk = ~clk;

    fat_chain_block_allocator #(.NUM_BLOCKS(NUM_BLOCKS)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .block        (block),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_block (result_block),
        .chain_count  (chain_count),
        .status       (status)
    );

    chain_table_checker #(.NUM_BLOCKS(NUM_BLOCKS)) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .block        (block),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_block (result_block),
        .chain_count  (chain_count),
        .status       (status),
        .mismatches   (mismatches),
        .in_flight    (in_flight)
    );

    // track freshly allocated blocks to steer later extends, frees and counts
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready && status == ST_OK && chain_count == 0)
        begin
            last_block <= result_block;
            recent_blocks[recent_slot] <= result_block;
            recent_slot <= recent_slot + 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : receiver
        int held;
        forever
        begin
            @(posedge clk);
            if (hold_off_taken != hold_off_asked)
            begin
                hold_off_taken = hold_off_asked;
                out_ready <= 1'b0;
                for (held = 0; held < HOLD_OFF_CYCLES; held++)
                    @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_request(input op_t op, input logic [BLK_W-1:0] blk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        block <= blk;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic random_request(input bit growing);
        int roll;
        int pick;
        op_t op;
        logic [BLK_W-1:0] blk;
        roll = $urandom_range(99);
        if (growing)
        begin
            if (roll < 30)
                op = OP_ALLOC;
            else if (roll < 75)
                op = OP_EXTEND;
            else if (roll < 85)
                op = OP_COUNT;
            else
                op = OP_FREE;
        end
        else
        begin
            if (roll < 10)
                op = OP_ALLOC;
            else if (roll < 25)
                op = OP_EXTEND;
            else if (roll < 55)
                op = OP_COUNT;
            else
                op = OP_FREE;
        end
        pick = $urandom_range(9);
        if (pick < 4)
            blk = last_block;
        else if (pick < 7)
            blk = recent_blocks[3'($urandom_range(7))];
        else
            blk = BLK_W'($urandom_range(2 ** BLK_W - 1));
        send_request(op, blk);
    endtask

    initial
    begin : stimulus
        int n;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_COUNT, 6'd0);
        send_request(OP_FREE, 6'd63);
        send_request(OP_EXTEND, 6'd63);
        send_request(OP_ALLOC, 6'd0);
        send_request(OP_ALLOC, 6'd63);
        send_request(OP_EXTEND, 6'd0);
        send_request(OP_EXTEND, 6'd2);
        send_request(OP_EXTEND, 6'd0);
        send_request(OP_COUNT, 6'd0);
        send_request(OP_COUNT, 6'd63);
        send_request(OP_FREE, 6'd2);
        send_request(OP_COUNT, 6'd0);
        send_request(OP_FREE, 6'd0);
        send_request(OP_ALLOC, 6'd0);
        send_request(OP_EXTEND, 6'd1);
        send_request(OP_EXTEND, 6'd2);
        send_request(OP_EXTEND, 6'd3);
        send_request(OP_COUNT, 6'd1);
        send_request(OP_FREE, 6'd1);
        send_request(OP_COUNT, 6'd0);
        send_request(OP_FREE, 6'd0);
        send_request(OP_ALLOC, 6'd0);
        send_request(OP_EXTEND, 6'd0);
        send_request(OP_FREE, 6'd0);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                send_idle_pct <= 47;
                recv_idle_pct <= 19;
            end
            else if (n == 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end
            if (n == HOLD_OFF_AT)
                hold_off_asked <= hold_off_asked + 1;
            random_request((n % SEGMENT_ITEMS) < GROW_ITEMS);
        end
        in_valid <= 1'b0;

        do
            @(posedge clk);
        while (in_flight != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
